// ===== design/doubly_linked_list_engine_top_assert.svh =====
// assertion macros shared by the list engine
`ifndef DOUBLY_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DLLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DLLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dlle_pkg.sv =====
package dlle_pkg;

    localparam int NODE_COUNT = 256;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int LINK_W     = IDX_W + 1;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NODE_COUNT);

    typedef enum logic [2:0] {
        OP_APPEND     = 3'd0,
        OP_PREPEND    = 3'd1,
        OP_INS_BEFORE = 3'd2,
        OP_INS_AFTER  = 3'd3,
        OP_UNLINK     = 3'd4,
        OP_CLEAR      = 3'd5,
        OP_QUERY      = 3'd6
    } t_op;

    // one write port of a link memory
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } t_wr;

endpackage

// ===== design/doubly_linked_list_engine_top.sv =====
// an item passes the read and second write states, then its result is
// registered; a result-side stall holds it there and no new item is taken until
// it leaves. New node links are written in the read state, neighbor links in the
// second write state, via each link memory's one write port; clear alike.
// reset: synchronous, active low; head and tail go to none, count to zero and
// the per-entry valid flags clear at once, so every link reads as none
module doubly_linked_list_engine_top import dlle_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_op,
    input  logic [IDX_W-1:0]  i_node_index,
    input  logic [IDX_W-1:0]  i_anchor_index,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [LINK_W-1:0] o_head_out,
    output logic [LINK_W-1:0] o_tail_out,
    output logic [LINK_W-1:0] o_count_out,
    output logic              o_is_empty,
    output logic [LINK_W-1:0] o_node_prev,
    output logic [LINK_W-1:0] o_node_next
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR2
    } t_state;

    t_state r_state;

    logic [2:0]        r_op;
    logic [IDX_W-1:0]  r_node;
    logic [IDX_W-1:0]  r_anc;
    logic [LINK_W-1:0] r_head, r_tail, r_count;
    logic [LINK_W-1:0] n_head, n_tail, n_count;

    logic [LINK_W-1:0] prev_mem [NODE_COUNT];
    logic [LINK_W-1:0] next_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_vld;

    logic [LINK_W-1:0] r_prv_rd_nd, r_prv_rd_an, r_nxt_rd_nd, r_nxt_rd_an;
    logic              r_v_nd, r_v_an;
    logic              r_prv_hit_nd, r_prv_hit_an, r_nxt_hit_nd, r_nxt_hit_an;
    logic [LINK_W-1:0] r_prv_fwd, r_nxt_fwd;
    logic [LINK_W-1:0] prv_nd, prv_an, nxt_nd, nxt_an;

    t_wr prv_wr, nxt_wr;
    t_wr r_prv_w2, r_nxt_w2, n_prv_w2, n_nxt_w2;

    logic              w1_en;
    logic [LINK_W-1:0] w1_prv, w1_nxt;
    logic              clr;
    logic [LINK_W-1:0] node9, anc9;
    logic              nd_linked, an_linked;
    logic              do_after, do_before, do_first, do_unlink;
    logic [LINK_W-1:0] n_res_prv, n_res_nxt, r_res_prv, r_res_nxt;

    logic              r_out_vld;
    logic [LINK_W-1:0] r_o_head, r_o_tail, r_o_count, r_o_prev, r_o_next;
    logic              r_o_empty;

    logic              accept, leave;
    logic [IDX_W-1:0]  rd_anc;

    logic              empty_agree, any_wr;

    // handshake
    assign leave   = (r_state == S_WR2) && (!r_out_vld || !i_stall);
    assign o_stall = !((r_state == S_IDLE) || leave);
    assign accept  = i_valid && !o_stall;

    // append and prepend use the tail or head as their anchor
    always_comb begin
        unique case (i_op)
            OP_APPEND:  rd_anc = r_tail[IDX_W-1:0];
            OP_PREPEND: rd_anc = r_head[IDX_W-1:0];
            default:    rd_anc = i_anchor_index;
        endcase
    end

    // link memories, two read addresses each, write data forwarded on a hit
    always_ff @(posedge i_clk) begin
        if (prv_wr.en) begin
            prev_mem[prv_wr.addr] <= prv_wr.data;
        end
        if (nxt_wr.en) begin
            next_mem[nxt_wr.addr] <= nxt_wr.data;
        end
        if (accept) begin
            r_prv_rd_nd  <= prev_mem[i_node_index];
            r_prv_rd_an  <= prev_mem[rd_anc];
            r_nxt_rd_nd  <= next_mem[i_node_index];
            r_nxt_rd_an  <= next_mem[rd_anc];
            r_v_nd       <= r_vld[i_node_index];
            r_v_an       <= r_vld[rd_anc];
            r_prv_hit_nd <= prv_wr.en && (prv_wr.addr == i_node_index);
            r_prv_hit_an <= prv_wr.en && (prv_wr.addr == rd_anc);
            r_nxt_hit_nd <= nxt_wr.en && (nxt_wr.addr == i_node_index);
            r_nxt_hit_an <= nxt_wr.en && (nxt_wr.addr == rd_anc);
            r_prv_fwd    <= prv_wr.data;
            r_nxt_fwd    <= nxt_wr.data;
        end
    end

    // one flag per node, set when both its links are written in the read state;
    // neighbor writes only reach linked nodes, whose flag is already set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (clr) begin
            r_vld <= '0;
        end else if (w1_en) begin
            r_vld[r_node] <= 1'b1;
        end
    end

    assign prv_nd = r_prv_hit_nd ? r_prv_fwd : (r_v_nd ? r_prv_rd_nd : LINK_NONE);
    assign prv_an = r_prv_hit_an ? r_prv_fwd : (r_v_an ? r_prv_rd_an : LINK_NONE);
    assign nxt_nd = r_nxt_hit_nd ? r_nxt_fwd : (r_v_nd ? r_nxt_rd_nd : LINK_NONE);
    assign nxt_an = r_nxt_hit_an ? r_nxt_fwd : (r_v_an ? r_nxt_rd_an : LINK_NONE);

    assign node9     = LINK_W'(r_node);
    assign anc9      = LINK_W'(r_anc);
    assign nd_linked = (prv_nd != LINK_NONE) || (nxt_nd != LINK_NONE) || (r_head == node9);
    assign an_linked = (prv_an != LINK_NONE) || (nxt_an != LINK_NONE) || (r_head == anc9);

    // operation decode
    always_comb begin
        do_after  = 1'b0;
        do_before = 1'b0;
        do_first  = 1'b0;
        do_unlink = 1'b0;
        clr       = 1'b0;
        if (r_state == S_RD) begin
            unique case (r_op)
                OP_APPEND: begin
                    if (!nd_linked) begin
                        do_after = (r_tail != LINK_NONE);
                        do_first = (r_tail == LINK_NONE);
                    end
                end
                OP_PREPEND: begin
                    if (!nd_linked) begin
                        do_before = (r_head != LINK_NONE);
                        do_first  = (r_head == LINK_NONE);
                    end
                end
                OP_INS_BEFORE: do_before = !nd_linked && an_linked;
                OP_INS_AFTER:  do_after  = !nd_linked && an_linked;
                OP_UNLINK:     do_unlink = nd_linked;
                OP_CLEAR:      clr       = 1'b1;
                default:       clr       = 1'b0;
            endcase
        end
    end

    // new link values, neighbor writes for the second write state and list registers
    always_comb begin
        w1_en         = 1'b0;
        w1_prv        = LINK_NONE;
        w1_nxt        = LINK_NONE;
        n_prv_w2.en   = 1'b0;
        n_prv_w2.addr = r_anc;
        n_prv_w2.data = node9;
        n_nxt_w2.en   = 1'b0;
        n_nxt_w2.addr = r_anc;
        n_nxt_w2.data = node9;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        if (do_after) begin
            w1_en       = 1'b1;
            w1_prv      = anc9;
            w1_nxt      = nxt_an;
            n_nxt_w2.en = 1'b1;
            if (nxt_an != LINK_NONE) begin
                n_prv_w2.en   = 1'b1;
                n_prv_w2.addr = nxt_an[IDX_W-1:0];
            end else begin
                n_tail = node9;
            end
            n_count = r_count + 1'b1;
        end else if (do_before) begin
            w1_en       = 1'b1;
            w1_prv      = prv_an;
            w1_nxt      = anc9;
            n_prv_w2.en = 1'b1;
            if (prv_an != LINK_NONE) begin
                n_nxt_w2.en   = 1'b1;
                n_nxt_w2.addr = prv_an[IDX_W-1:0];
            end else begin
                n_head = node9;
            end
            n_count = r_count + 1'b1;
        end else if (do_first) begin
            w1_en   = 1'b1;
            n_head  = node9;
            n_tail  = node9;
            n_count = r_count + 1'b1;
        end else if (do_unlink) begin
            w1_en         = 1'b1;
            n_prv_w2.en   = (nxt_nd != LINK_NONE) && (r_tail != node9);
            n_prv_w2.addr = nxt_nd[IDX_W-1:0];
            n_prv_w2.data = (r_head == node9) ? LINK_NONE : prv_nd;
            n_nxt_w2.en   = (prv_nd != LINK_NONE) && (r_head != node9);
            n_nxt_w2.addr = prv_nd[IDX_W-1:0];
            n_nxt_w2.data = (r_tail == node9) ? LINK_NONE : nxt_nd;
            if ((r_head == node9) && (r_tail == node9)) begin
                n_head = LINK_NONE;
                n_tail = LINK_NONE;
            end else if (r_head == node9) begin
                n_head = nxt_nd;
            end else if (r_tail == node9) begin
                n_tail = prv_nd;
            end
            if (r_count != '0) begin
                n_count = r_count - 1'b1;
            end
        end else if (clr) begin
            n_head  = LINK_NONE;
            n_tail  = LINK_NONE;
            n_count = '0;
        end
    end

    assign n_res_prv = clr ? LINK_NONE : (w1_en ? w1_prv : prv_nd);
    assign n_res_nxt = clr ? LINK_NONE : (w1_en ? w1_nxt : nxt_nd);

    // write ports: new node first, neighbors on the cycle the result leaves
    always_comb begin
        if (r_state == S_RD) begin
            prv_wr.en   = w1_en;
            prv_wr.addr = r_node;
            prv_wr.data = w1_prv;
            nxt_wr.en   = w1_en;
            nxt_wr.addr = r_node;
            nxt_wr.data = w1_nxt;
        end else begin
            prv_wr    = r_prv_w2;
            prv_wr.en = r_prv_w2.en && leave;
            nxt_wr    = r_nxt_w2;
            nxt_wr.en = r_nxt_w2.en && leave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_head    <= LINK_NONE;
            r_tail    <= LINK_NONE;
            r_count   <= '0;
        end else begin
            if (leave) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state   <= S_WR2;
                    r_head    <= n_head;
                    r_tail    <= n_tail;
                    r_count   <= n_count;
                    r_prv_w2  <= n_prv_w2;
                    r_nxt_w2  <= n_nxt_w2;
                    r_res_prv <= n_res_prv;
                    r_res_nxt <= n_res_nxt;
                end
                S_WR2: begin
                    if (leave) begin
                        r_state <= accept ? S_RD : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (accept) begin
                r_op   <= i_op;
                r_node <= i_node_index;
                r_anc  <= rd_anc;
            end
            if (leave) begin
                r_o_head  <= r_head;
                r_o_tail  <= r_tail;
                r_o_count <= r_count;
                r_o_empty <= (r_count == '0);
                r_o_prev  <= r_res_prv;
                r_o_next  <= r_res_nxt;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_head_out  = r_o_head;
    assign o_tail_out  = r_o_tail;
    assign o_count_out = r_o_count;
    assign o_is_empty  = r_o_empty;
    assign o_node_prev = r_o_prev;
    assign o_node_next = r_o_next;

    assign empty_agree = ((r_count == '0) == (r_head == LINK_NONE)) &&
                         ((r_head == LINK_NONE) == (r_tail == LINK_NONE));
    assign any_wr      = prv_wr.en || nxt_wr.en;

`include "doubly_linked_list_engine_top_assert.svh"

    `DLLE_ASSERT_IMPL(a_empty_agree, 1'b1, empty_agree, "head, tail and count disagree on empty")
    `DLLE_ASSERT_IMPL(a_count_range, 1'b1, r_count <= LINK_W'(NODE_COUNT), "count too large")
    `DLLE_ASSERT_IMPL(a_idle_no_write, r_state == S_IDLE, !any_wr, "link write while idle")
    `DLLE_ASSERT_NEXT(a_accept_reads, accept, r_state == S_RD, "item did not reach read stage")

endmodule

// ===== tb/doubly_linked_list_engine_top_tb.sv =====
module doubly_linked_list_engine_top_tb;
    import dlle_pkg::*;

    // op code outside the defined set, behaves as a query
    localparam logic [2:0] OP_RESERVED = 3'd7;
    localparam int TARGET_ITEMS = 1350;
    localparam int IDLE_LIMIT   = 4000;
    localparam int MAX_SHOWN    = 10;
    localparam int TAIL_CYCLES  = 12;

    typedef struct {
        logic [2:0]       op;
        logic [IDX_W-1:0] node;
        logic [IDX_W-1:0] anchor;
        bit               drain;
    } t_list_req;

    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
        logic [LINK_W-1:0] count;
        logic              empty;
        logic [LINK_W-1:0] prv;
        logic [LINK_W-1:0] nxt;
    } t_list_view;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [2:0]        i_op = '0;
    logic [IDX_W-1:0]  i_node_index = '0;
    logic [IDX_W-1:0]  i_anchor_index = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [LINK_W-1:0] o_head_out;
    logic [LINK_W-1:0] o_tail_out;
    logic [LINK_W-1:0] o_count_out;
    logic              o_is_empty;
    logic [LINK_W-1:0] o_node_prev;
    logic [LINK_W-1:0] o_node_next;

    doubly_linked_list_engine_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_node_index   (i_node_index),
        .i_anchor_index (i_anchor_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_head_out     (o_head_out),
        .o_tail_out     (o_tail_out),
        .o_count_out    (o_count_out),
        .o_is_empty     (o_is_empty),
        .o_node_prev    (o_node_prev),
        .o_node_next    (o_node_next)
    );

    always #10 i_clk = ~i_clk;

    t_list_req  pending_ops[$];
    t_list_view expected_views[$];

    // list picture used to predict results
    logic [LINK_W-1:0] mdl_prev[NODE_COUNT];
    logic [LINK_W-1:0] mdl_next[NODE_COUNT];
    logic [LINK_W-1:0] mdl_head;
    logic [LINK_W-1:0] mdl_tail;
    logic [LINK_W-1:0] mdl_count;

    // membership as seen by the stimulus generator
    bit gen_on[NODE_COUNT];
    int gen_size = 0;

    int accepted_items = 0;
    int presented_items = 0;
    int results_checked = 0;
    int mismatches = 0;
    int clears_seen = 0;
    int peak_count = 0;
    int quiet_cycles = 0;
    int idle_mode = 1;
    int send_gap = 0;
    int stall_hold = 0;
    int cycle_count = 0;

    function automatic bit model_linked(logic [LINK_W-1:0] n);
        if (n >= NODE_COUNT)
            return 1'b0;
        return mdl_prev[n] != LINK_NONE || mdl_next[n] != LINK_NONE || mdl_head == n;
    endfunction

    function automatic void model_put_first(logic [LINK_W-1:0] n);
        mdl_head = n;
        mdl_tail = n;
        mdl_prev[n] = LINK_NONE;
        mdl_next[n] = LINK_NONE;
        mdl_count++;
    endfunction

    function automatic void model_link_after(logic [LINK_W-1:0] n, logic [LINK_W-1:0] a);
        logic [LINK_W-1:0] succ;
        succ = mdl_next[a];
        mdl_prev[n] = a;
        mdl_next[n] = succ;
        if (succ < NODE_COUNT)
            mdl_prev[succ] = n;
        else
            mdl_tail = n;
        mdl_next[a] = n;
        mdl_count++;
    endfunction

    function automatic void model_link_before(logic [LINK_W-1:0] n, logic [LINK_W-1:0] a);
        logic [LINK_W-1:0] pred;
        pred = mdl_prev[a];
        mdl_prev[n] = pred;
        mdl_next[n] = a;
        if (pred < NODE_COUNT)
            mdl_next[pred] = n;
        else
            mdl_head = n;
        mdl_prev[a] = n;
        mdl_count++;
    endfunction

    function automatic void model_unlink(logic [LINK_W-1:0] n);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] s;
        p = mdl_prev[n];
        s = mdl_next[n];
        if (mdl_head == n && mdl_tail == n) begin
            mdl_head = LINK_NONE;
            mdl_tail = LINK_NONE;
        end else if (mdl_head == n) begin
            mdl_head = s;
            if (s < NODE_COUNT)
                mdl_prev[s] = LINK_NONE;
        end else if (mdl_tail == n) begin
            mdl_tail = p;
            if (p < NODE_COUNT)
                mdl_next[p] = LINK_NONE;
        end else begin
            if (p < NODE_COUNT)
                mdl_next[p] = s;
            if (s < NODE_COUNT)
                mdl_prev[s] = p;
        end
        mdl_prev[n] = LINK_NONE;
        mdl_next[n] = LINK_NONE;
        if (mdl_count > 0)
            mdl_count--;
    endfunction

    function automatic void model_clear();
        logic [LINK_W-1:0] cursor;
        logic [LINK_W-1:0] following;
        int steps;
        cursor = mdl_head;
        steps = 0;
        while (cursor < NODE_COUNT && steps < NODE_COUNT) begin
            following = mdl_next[cursor];
            mdl_prev[cursor] = LINK_NONE;
            mdl_next[cursor] = LINK_NONE;
            cursor = following;
            steps++;
        end
        mdl_head = LINK_NONE;
        mdl_tail = LINK_NONE;
        mdl_count = '0;
    endfunction

    // applies one list op and returns the view the block must report
    function automatic t_list_view list_apply(logic [2:0] op, logic [IDX_W-1:0] node,
                                              logic [IDX_W-1:0] anchor);
        logic [LINK_W-1:0] n;
        logic [LINK_W-1:0] a;
        bit node_free;
        t_list_view view;
        n = {1'b0, node};
        a = {1'b0, anchor};
        node_free = !model_linked(n);
        case (op)
            OP_APPEND: begin
                if (node_free) begin
                    if (mdl_tail < NODE_COUNT)
                        model_link_after(n, mdl_tail);
                    else
                        model_put_first(n);
                end
            end
            OP_PREPEND: begin
                if (node_free) begin
                    if (mdl_head < NODE_COUNT)
                        model_link_before(n, mdl_head);
                    else
                        model_put_first(n);
                end
            end
            OP_INS_BEFORE: begin
                if (node_free && model_linked(a))
                    model_link_before(n, a);
            end
            OP_INS_AFTER: begin
                if (node_free && model_linked(a))
                    model_link_after(n, a);
            end
            OP_UNLINK: begin
                if (!node_free)
                    model_unlink(n);
            end
            OP_CLEAR: model_clear();
            default: ;
        endcase
        view.head  = mdl_head;
        view.tail  = mdl_tail;
        view.count = mdl_count;
        view.empty = (mdl_count == 0);
        view.prv   = mdl_prev[n];
        view.nxt   = mdl_next[n];
        return view;
    endfunction

    function automatic int gen_pick(bit want_linked);
        int avail;
        int k;
        int idx;
        avail = want_linked ? gen_size : NODE_COUNT - gen_size;
        if (avail == 0)
            return $urandom_range(0, NODE_COUNT - 1);
        k = $urandom_range(0, avail - 1);
        for (idx = 0; idx < NODE_COUNT; idx++) begin
            if (gen_on[idx] == want_linked) begin
                if (k == 0)
                    return idx;
                k--;
            end
        end
        return 0;
    endfunction

    // queues one item; returns 1 when the item does more than get ignored
    function automatic bit gen_push(logic [2:0] op, int node, int anchor, bit drain);
        t_list_req req;
        bit useful;
        int idx;
        req.op     = op;
        req.node   = node[IDX_W-1:0];
        req.anchor = anchor[IDX_W-1:0];
        req.drain  = drain;
        pending_ops.push_back(req);
        useful = 1'b1;
        case (op)
            OP_APPEND, OP_PREPEND: useful = !gen_on[node];
            OP_INS_BEFORE, OP_INS_AFTER: useful = !gen_on[node] && gen_on[anchor];
            OP_UNLINK: useful = gen_on[node];
            default: ;
        endcase
        if (useful) begin
            case (op)
                OP_APPEND, OP_PREPEND, OP_INS_BEFORE, OP_INS_AFTER: begin
                    gen_on[node] = 1'b1;
                    gen_size++;
                end
                OP_UNLINK: begin
                    gen_on[node] = 1'b0;
                    gen_size--;
                end
                OP_CLEAR: begin
                    for (idx = 0; idx < NODE_COUNT; idx++)
                        gen_on[idx] = 1'b0;
                    gen_size = 0;
                end
                default: ;
            endcase
        end
        return useful;
    endfunction

    // mostly short gaps, a few long ones, none at all in quiet mode
    function automatic int pick_gap();
        int r;
        if (idle_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < (idle_mode == 1 ? 70 : 40))
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    always @(negedge i_clk) begin
        t_list_req req;
        logic next_valid;
        bit busy;
        busy = i_valid && accepted_items != presented_items;
        if (i_rst_n && !busy) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_ops.size() > 0 &&
                         !(pending_ops[0].drain && expected_views.size() > 0)) begin
                req = pending_ops.pop_front();
                i_op <= req.op;
                i_node_index <= req.node;
                i_anchor_index <= req.anchor;
                next_valid = 1'b1;
                presented_items++;
                send_gap = pick_gap();
            end
            i_valid <= next_valid;
        end
    end

    // result-side stall, plus the idling mode shared by both sides
    always @(negedge i_clk) begin
        int len;
        cycle_count++;
        if (cycle_count % 150 == 0)
            idle_mode = $urandom_range(0, 2);
        if (i_rst_n) begin
            if (stall_hold > 0) begin
                stall_hold--;
            end else if (i_stall) begin
                i_stall <= 1'b0;
                stall_hold = $urandom_range(0, 6);
            end else begin
                len = pick_gap();
                if (len > 0) begin
                    i_stall <= 1'b1;
                    stall_hold = len - 1;
                end
            end
        end
    end

    // monitor: predicts on each accepted item, checks each accepted result
    always @(posedge i_clk) begin
        t_list_view want;
        t_list_view got;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want = list_apply(i_op, i_node_index, i_anchor_index);
                expected_views.push_back(want);
                accepted_items++;
                if (i_op == OP_CLEAR)
                    clears_seen++;
                if (mdl_count > peak_count)
                    peak_count = mdl_count;
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                got.head  = o_head_out;
                got.tail  = o_tail_out;
                got.count = o_count_out;
                got.empty = o_is_empty;
                got.prv   = o_node_prev;
                got.nxt   = o_node_next;
                results_checked++;
                moved = 1'b1;
                if (expected_views.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("unexpected item: head %0d tail %0d count %0d",
                                 got.head, got.tail, got.count);
                        $display("  empty %0d prev %0d next %0d",
                                 got.empty, got.prv, got.nxt);
                    end
                end else begin
                    want = expected_views.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN) begin
                            $display("mismatch on result %0d:", results_checked);
                            $display("  exp head %0d tail %0d count %0d empty %0d prev %0d next %0d",
                                     want.head, want.tail, want.count,
                                     want.empty, want.prv, want.nxt);
                            $display("  got head %0d tail %0d count %0d empty %0d prev %0d next %0d",
                                     got.head, got.tail, got.count,
                                     got.empty, got.prv, got.nxt);
                        end
                    end
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int idx;
        int useful_items;
        int guard;
        int r;
        int node;
        int anchor;
        logic [2:0] op;

        for (idx = 0; idx < NODE_COUNT; idx++) begin
            mdl_prev[idx] = LINK_NONE;
            mdl_next[idx] = LINK_NONE;
            gen_on[idx] = 1'b0;
        end
        mdl_head = LINK_NONE;
        mdl_tail = LINK_NONE;
        mdl_count = '0;

        // directed: empty list cases, ends of the list, ignored requests
        void'(gen_push(OP_QUERY, 0, 255, 1'b0));
        void'(gen_push(OP_INS_BEFORE, 5, 0, 1'b0));
        void'(gen_push(OP_INS_AFTER, 5, 0, 1'b0));
        void'(gen_push(OP_UNLINK, 0, 0, 1'b0));
        void'(gen_push(OP_APPEND, 0, 255, 1'b0));
        void'(gen_push(OP_APPEND, 255, 0, 1'b0));
        void'(gen_push(OP_PREPEND, 128, 0, 1'b0));
        void'(gen_push(OP_APPEND, 0, 0, 1'b0));
        void'(gen_push(OP_INS_BEFORE, 10, 255, 1'b0));
        void'(gen_push(OP_INS_AFTER, 20, 0, 1'b0));
        void'(gen_push(OP_INS_AFTER, 30, 255, 1'b0));
        void'(gen_push(OP_INS_BEFORE, 40, 128, 1'b0));
        void'(gen_push(OP_INS_BEFORE, 50, 77, 1'b0));
        void'(gen_push(OP_INS_AFTER, 20, 128, 1'b0));
        void'(gen_push(OP_RESERVED, 10, 255, 1'b0));
        void'(gen_push(OP_UNLINK, 40, 0, 1'b0));
        void'(gen_push(OP_UNLINK, 30, 0, 1'b0));
        void'(gen_push(OP_UNLINK, 10, 0, 1'b0));
        void'(gen_push(OP_QUERY, 255, 0, 1'b1));
        void'(gen_push(OP_CLEAR, 0, 255, 1'b0));
        void'(gen_push(OP_QUERY, 0, 0, 1'b0));
        void'(gen_push(OP_PREPEND, 200, 0, 1'b0));
        void'(gen_push(OP_UNLINK, 200, 0, 1'b0));
        void'(gen_push(OP_CLEAR, 255, 0, 1'b1));
        void'(gen_push(OP_APPEND, 7, 0, 1'b0));

        useful_items = 0;
        guard = 0;
        while (pending_ops.size() < TARGET_ITEMS && guard < 20 * TARGET_ITEMS) begin
            guard++;
            if (useful_items == 400 || useful_items == 900) begin
                // fill the whole pool, poke the full list, then clear it
                while (gen_size < NODE_COUNT) begin
                    op = 3'($urandom_range(OP_APPEND, OP_INS_AFTER));
                    useful_items += gen_push(op, gen_pick(1'b0), gen_pick(1'b1), 1'b0);
                end
                for (idx = 0; idx < 6; idx++)
                    void'(gen_push(($urandom_range(0, 1) ? OP_QUERY : OP_APPEND),
                                   $urandom_range(0, 255), $urandom_range(0, 255),
                                   idx == 0));
                useful_items += gen_push(OP_CLEAR, $urandom_range(0, 255),
                                         $urandom_range(0, 255), 1'b0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    op = OP_APPEND;
                else if (r < 32)
                    op = OP_PREPEND;
                else if (r < 46)
                    op = OP_INS_BEFORE;
                else if (r < 60)
                    op = OP_INS_AFTER;
                else if (r < 80)
                    op = OP_UNLINK;
                else if (r < 82)
                    op = OP_CLEAR;
                else if (r < 93)
                    op = OP_QUERY;
                else
                    op = OP_RESERVED;
                if ($urandom_range(0, 99) < 85)
                    node = gen_pick(!(op inside {OP_APPEND, OP_PREPEND, OP_INS_BEFORE,
                                                 OP_INS_AFTER}));
                else
                    node = $urandom_range(0, 255);
                anchor = ($urandom_range(0, 99) < 85) ? gen_pick(1'b1) : $urandom_range(0, 255);
                useful_items += gen_push(op, node, anchor, $urandom_range(0, 99) == 0);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && accepted_items == presented_items &&
              expected_views.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d list ops with %0d clears, longest list %0d nodes",
                 accepted_items, clears_seen, peak_count);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_views.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/dlle_pkg.sv
design/doubly_linked_list_engine_top.sv
tb/doubly_linked_list_engine_top_tb.sv
